@@ rtl/core/sbb_pkg.sv @@
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none
package sbb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 15;
   localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
   localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int RING_W = $clog2(RING_ROWS);
   localparam int SLOT_W = RING_W + COL_W;

   localparam int FW_W = 11;
   localparam int FH_W = 13;
   localparam int FR_W = 4;
   localparam int POS_W = 23;
   localparam int LAG_W = 15;
   localparam int DIV_W = 5;
   localparam int TAP_W = 5;
   localparam int SUM_W = 13;
   localparam int QBIT_W = 3;
   localparam int PIX_W = 24;
   localparam int ORIG_W = 25;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = FW_W'(640);
   localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = FH_W'(480);
   localparam logic [FR_W-1:0] RST_BLUR_RADIUS  = FR_W'(1);

   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BLUR_RADIUS  = 2'd2;

   typedef struct packed {
      logic take;
      logic orig_wr;
      logic in_adv;
      logic task_setup;
      logic tap_clr;
      logic tap_acc;
      logic col_mode;
      logic div_init;
      logic div_step;
      logic blur_wr;
      logic out_rd;
      logic orig_cap;
      logic out_load;
   } sbb_cmd_type;

   typedef struct packed {
      logic push_ok;
      logic need_row;
      logic taps_last;
      logic div_last;
      logic rx_last;
      logic out_due;
      logic orig_sel;
      logic out_free;
   } sbb_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/sbb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/core/sbb_datapath.sv @@
// Datapath: registers, stores, window accumulators, divider and result register.
`default_nettype none
module sbb_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sbb_pkg::sbb_cmd_type            cmd,
   output sbb_pkg::sbb_stat_type                stat,
   input  wire logic                            csr_wr,
   input  wire logic [sbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  wire logic                            req_operation,
   input  wire logic [7:0]                      req_red_in,
   input  wire logic [7:0]                      req_green_in,
   input  wire logic [7:0]                      req_blue_in,
   input  wire logic                            req_selected,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_red_out,
   output logic [7:0]                           rsp_green_out,
   output logic [7:0]                           rsp_blue_out,
   output logic                                 rsp_frame_end
);
   import sbb_pkg::*;

   logic [FW_W-1:0]   width_ff;
   logic [FH_W-1:0]   height_ff;
   logic [FR_W-1:0]   radius_ff;
   logic [1:0]        csr_idx;
   logic              cfg_hit;

   logic [FW_W-1:0]   uw_c;
   logic [FH_W-1:0]   uh_c;
   logic [FR_W-1:0]   r_max_c;
   logic [FR_W-1:0]   r_w_c;
   logic [FR_W-1:0]   ur_c;
   logic [FW_W-1:0]   half_w_c;
   logic [FH_W-1:0]   half_h_c;

   logic [FR_W-1:0]   ur_ff;
   logic [DIV_W-1:0]  d_ff;
   logic [COL_W-1:0]  wm1_ff;
   logic [ROW_W-1:0]  hm1_ff;
   logic [POS_W-1:0]  n_ff;
   logic [LAG_W-1:0]  lag_ff;

   logic [POS_W-1:0]  in_pos_ff;
   logic [COL_W-1:0]  in_col_ff;
   logic [RING_W-1:0] in_row_ff;
   logic [POS_W-1:0]  out_pos_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;

   logic              op_ff;
   logic [ORIG_W-1:0] pix_ff;

   logic [COL_W-1:0]  rx_ff;
   logic [COL_W-1:0]  rx_end_ff;
   logic [RING_W-1:0] trow_ff;
   logic [COL_W-1:0]  col_sub_c;

   logic [TAP_W-1:0]  k_ff;
   logic [SUM_W-1:0]  acc_ff [3];
   logic [SUM_W-1:0]  rem_ff [3];
   logic [7:0]        quo_ff [3];
   logic [QBIT_W-1:0] qbit_ff;
   logic [SUM_W-1:0]  div_sh_c;

   logic [COL_W+1:0]  rt_c;
   logic [COL_W+1:0]  rt_off_c;
   logic [COL_W-1:0]  rt_col_c;
   logic [ROW_W:0]    ct_c;
   logic [ROW_W:0]    ct_off_c;
   logic [ROW_W-1:0]  ct_row_c;

   logic [SLOT_W-1:0] orig_raddr;
   logic [SLOT_W-1:0] blur_raddr;
   logic [ORIG_W-1:0] orig_rdata;
   logic [PIX_W-1:0]  blur_rdata;
   logic [PIX_W-1:0]  tap_data_c;

   logic [ORIG_W-1:0] orig_ff;
   logic [POS_W-1:0]  need_c;
   logic [POS_W-1:0]  last_pos_c;
   logic              frame_last_c;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_pix_ff;
   logic              rsp_end_ff;

   // configuration registers
   assign csr_idx = csr_paddr[3:2];
   assign cfg_hit = csr_wr && (csr_idx == REG_FRAME_WIDTH || csr_idx == REG_FRAME_HEIGHT ||
                               csr_idx == REG_BLUR_RADIUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         radius_ff <= RST_BLUR_RADIUS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_pwdata[FH_W-1:0];
            REG_BLUR_RADIUS:  radius_ff <= csr_pwdata[FR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_BLUR_RADIUS:  csr_prdata = CSR_DATA_W'(radius_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamped geometry
   always_comb begin
      if (width_ff == '0)                    uw_c = FW_W'(1);
      else if (width_ff > FW_W'(MAX_WIDTH))  uw_c = FW_W'(MAX_WIDTH);
      else                                   uw_c = width_ff;
      if (height_ff == '0)                   uh_c = FH_W'(1);
      else if (height_ff > FH_W'(MAX_HEIGHT)) uh_c = FH_W'(MAX_HEIGHT);
      else                                   uh_c = height_ff;
      half_w_c = (uw_c - FW_W'(1)) >> 1;
      half_h_c = (uh_c - FH_W'(1)) >> 1;
      r_max_c  = (radius_ff > FR_W'(MAX_RADIUS)) ? FR_W'(MAX_RADIUS) : radius_ff;
      r_w_c    = (FW_W'(r_max_c) > half_w_c) ? half_w_c[FR_W-1:0] : r_max_c;
      ur_c     = (FH_W'(r_w_c) > half_h_c) ? half_h_c[FR_W-1:0] : r_w_c;
   end

   always_ff @(posedge clock) begin
      ur_ff  <= ur_c;
      d_ff   <= {ur_c, 1'b1};
      wm1_ff <= COL_W'(uw_c - FW_W'(1));
      hm1_ff <= ROW_W'(uh_c - FH_W'(1));
      n_ff   <= POS_W'(uw_c * uh_c);
      lag_ff <= LAG_W'(ur_c * uw_c) + LAG_W'(ur_c);
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_operation;
         pix_ff <= {req_selected, req_blue_in, req_green_in, req_red_in};
      end
   end

   // raster positions
   assign last_pos_c   = n_ff - POS_W'(1);
   assign frame_last_c = (out_pos_ff == last_pos_c);

   always_ff @(posedge clock) begin
      if (reset || cfg_hit || (cmd.out_load && stat.out_free && frame_last_c)) begin
         in_pos_ff  <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_pos_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         if (cmd.in_adv) begin
            in_pos_ff <= in_pos_ff + POS_W'(1);
            if (in_col_ff == wm1_ff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + RING_W'(1);
            end else begin
               in_col_ff <= in_col_ff + COL_W'(1);
            end
         end
         if (cmd.out_load && stat.out_free) begin
            out_pos_ff <= out_pos_ff + POS_W'(1);
            if (out_col_ff == wm1_ff) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + ROW_W'(1);
            end else begin
               out_col_ff <= out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // row-average task range
   assign col_sub_c = in_col_ff - COL_W'(ur_ff);

   always_ff @(posedge clock) begin
      if (cmd.task_setup) begin
         rx_ff     <= col_sub_c;
         rx_end_ff <= (in_col_ff == wm1_ff) ? wm1_ff : col_sub_c;
         trow_ff   <= in_row_ff;
      end else if (cmd.blur_wr) begin
         rx_ff <= rx_ff + COL_W'(1);
      end
   end

   // tap addresses, edge samples repeat
   always_comb begin
      rt_c     = (COL_W+2)'(rx_ff) + (COL_W+2)'(k_ff);
      rt_off_c = rt_c - (COL_W+2)'(ur_ff);
      if (rt_c < (COL_W+2)'(ur_ff))             rt_col_c = '0;
      else if (rt_off_c > (COL_W+2)'(wm1_ff))   rt_col_c = wm1_ff;
      else                                      rt_col_c = rt_off_c[COL_W-1:0];
      ct_c     = (ROW_W+1)'(out_row_ff) + (ROW_W+1)'(k_ff);
      ct_off_c = ct_c - (ROW_W+1)'(ur_ff);
      if (ct_c < (ROW_W+1)'(ur_ff))             ct_row_c = '0;
      else if (ct_off_c > (ROW_W+1)'(hm1_ff))   ct_row_c = hm1_ff;
      else                                      ct_row_c = ct_off_c[ROW_W-1:0];
   end

   assign orig_raddr = cmd.out_rd ? {out_row_ff[RING_W-1:0], out_col_ff}
                                  : {trow_ff, rt_col_c};
   assign blur_raddr = {ct_row_c[RING_W-1:0], out_col_ff};

   sbb_ram #(.WIDTH(ORIG_W), .DEPTH(STORE_DEPTH)) u_orig_ram (
      .clock (clock),
      .we    (cmd.orig_wr),
      .waddr ({in_row_ff, in_col_ff}),
      .wdata (pix_ff),
      .raddr (orig_raddr),
      .rdata (orig_rdata)
   );

   sbb_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_blur_ram (
      .clock (clock),
      .we    (cmd.blur_wr),
      .waddr ({trow_ff, rx_ff}),
      .wdata ({quo_ff[2], quo_ff[1], quo_ff[0]}),
      .raddr (blur_raddr),
      .rdata (blur_rdata)
   );

   // window accumulation and division by 2r+1
   assign tap_data_c = cmd.col_mode ? blur_rdata : orig_rdata[PIX_W-1:0];
   assign div_sh_c   = SUM_W'(d_ff) << qbit_ff;

   always_ff @(posedge clock) begin
      if (cmd.tap_clr) begin
         k_ff <= '0;
      end else if (cmd.tap_acc) begin
         k_ff <= k_ff + TAP_W'(1);
      end
      if (cmd.div_init) begin
         qbit_ff <= QBIT_W'(7);
      end else if (cmd.div_step) begin
         qbit_ff <= qbit_ff - QBIT_W'(1);
      end
      for (int ch = 0; ch < 3; ch++) begin
         if (cmd.tap_clr) begin
            acc_ff[ch] <= '0;
         end else if (cmd.tap_acc) begin
            acc_ff[ch] <= acc_ff[ch] + SUM_W'(tap_data_c[8*ch +: 8]);
         end
         if (cmd.div_init) begin
            rem_ff[ch] <= acc_ff[ch] + SUM_W'(ur_ff);
            quo_ff[ch] <= '0;
         end else if (cmd.div_step) begin
            if (rem_ff[ch] >= div_sh_c) begin
               rem_ff[ch]          <= rem_ff[ch] - div_sh_c;
               quo_ff[ch][qbit_ff] <= 1'b1;
            end
         end
      end
   end

   // result
   always_ff @(posedge clock) begin
      if (cmd.orig_cap) begin
         orig_ff <= orig_rdata;
      end
   end

   always_comb begin
      need_c = out_pos_ff + POS_W'(lag_ff);
      if (need_c > last_pos_c) begin
         need_c = last_pos_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load && stat.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load && stat.out_free) begin
         rsp_pix_ff <= orig_ff[ORIG_W-1] ? {quo_ff[2], quo_ff[1], quo_ff[0]}
                                         : orig_ff[PIX_W-1:0];
         rsp_end_ff <= frame_last_c;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[7:0];
   assign rsp_green_out = rsp_pix_ff[15:8];
   assign rsp_blue_out  = rsp_pix_ff[23:16];
   assign rsp_frame_end = rsp_end_ff;

   // status
   assign stat.push_ok   = !op_ff && (in_pos_ff < n_ff);
   assign stat.need_row  = (in_col_ff >= COL_W'(ur_ff));
   assign stat.taps_last = (k_ff == {ur_ff, 1'b0});
   assign stat.div_last  = (qbit_ff == '0);
   assign stat.rx_last   = (rx_ff == rx_end_ff);
   assign stat.out_due   = (out_pos_ff < n_ff) && (in_pos_ff > need_c);
   assign stat.orig_sel  = orig_rdata[ORIG_W-1];
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

@@ rtl/core/sbb_ctrl.sv @@
// Controller state machine sequencing stores, window taps and division.
`default_nettype none
module sbb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  cfg_wr,
   output logic                       req_ready,
   output sbb_pkg::sbb_cmd_type       cmd,
   input  wire sbb_pkg::sbb_stat_type stat
);
   import sbb_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_WRITE    = 4'd2;
   localparam logic [3:0] S_TAP_CLR  = 4'd3;
   localparam logic [3:0] S_TAP_ADDR = 4'd4;
   localparam logic [3:0] S_TAP_ACC  = 4'd5;
   localparam logic [3:0] S_DIV_INIT = 4'd6;
   localparam logic [3:0] S_DIV      = 4'd7;
   localparam logic [3:0] S_BLUR_WR  = 4'd8;
   localparam logic [3:0] S_OUT_CHK  = 4'd9;
   localparam logic [3:0] S_ORIG_RD  = 4'd10;
   localparam logic [3:0] S_ORIG_CAP = 4'd11;
   localparam logic [3:0] S_OUT_LOAD = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       col_mode_ff;
   logic       col_mode_in;

   assign req_ready = (state_ff == S_IDLE) && !cfg_wr;

   always_comb begin
      state_in    = state_ff;
      col_mode_in = col_mode_ff;
      cmd         = '0;
      cmd.col_mode = col_mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.push_ok ? S_WRITE : S_OUT_CHK;
         end
         S_WRITE: begin
            cmd.orig_wr    = 1'b1;
            cmd.task_setup = 1'b1;
            cmd.in_adv     = 1'b1;
            col_mode_in    = 1'b0;
            state_in       = stat.need_row ? S_TAP_CLR : S_OUT_CHK;
         end
         S_TAP_CLR: begin
            cmd.tap_clr = 1'b1;
            state_in    = S_TAP_ADDR;
         end
         S_TAP_ADDR: begin
            state_in = S_TAP_ACC;
         end
         S_TAP_ACC: begin
            cmd.tap_acc = 1'b1;
            state_in    = stat.taps_last ? S_DIV_INIT : S_TAP_ADDR;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = col_mode_ff ? S_OUT_LOAD : S_BLUR_WR;
            end
         end
         S_BLUR_WR: begin
            cmd.blur_wr = 1'b1;
            state_in    = stat.rx_last ? S_OUT_CHK : S_TAP_CLR;
         end
         S_OUT_CHK: begin
            state_in = stat.out_due ? S_ORIG_RD : S_IDLE;
         end
         S_ORIG_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = S_ORIG_CAP;
         end
         S_ORIG_CAP: begin
            cmd.orig_cap = 1'b1;
            col_mode_in  = 1'b1;
            state_in     = stat.orig_sel ? S_TAP_CLR : S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         col_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_mode_ff <= col_mode_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/separable_box_blur_rgb_top.sv @@
// Top level of the separable RGB box blur: controller, datapath and APB register port.
// Sequence: a push stores the pixel, then completes row averages (one, or r+1 at a row
//   end); a due result reads the stored pixel and waits out any output stall, and a selected
//   pixel first takes its column average over 2r+1 rows. A drain goes straight to the result check.
// Throughput: one transaction at a time; the tap loop reads one store word per address
//   and accumulate step, and the shared divider retires one quotient bit per cycle.
// Reset: synchronous, active high; clears registers to 640x480, radius 1, positions to 0.
`default_nettype none
module separable_box_blur_rgb_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input pixel channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_operation,
   input  wire logic [7:0]                      req_red_in,
   input  wire logic [7:0]                      req_green_in,
   input  wire logic [7:0]                      req_blue_in,
   input  wire logic                            req_selected,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_red_out,
   output logic [7:0]                           rsp_green_out,
   output logic [7:0]                           rsp_blue_out,
   output logic                                 rsp_frame_end,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import sbb_pkg::*;

   sbb_cmd_type  cmd;
   sbb_stat_type stat;
   logic         cfg_wr;

   // Register writes land in the access phase; hold off input transactions then.
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Sequence each transaction: store the pixel, finish row averages, then emit.
   sbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .cfg_wr    (cfg_wr),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Hold configuration, the pixel and row-average rings, and the result register.
   sbb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_wr        (cfg_wr),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .req_operation (req_operation),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_selected  (req_selected),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

@@ rtl/core/sbb_checker.sv @@
// Port-level checker for the box blur top level, with its bind statement.
`default_nettype none
module sbb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red_out,
   input wire logic [7:0] rsp_green_out,
   input wire logic [7:0] rsp_blue_out,
   input wire logic       rsp_frame_end,
   input wire logic       csr_psel,
   input wire logic       csr_penable,
   input wire logic       csr_pwrite,
   input wire logic       csr_pready
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

   a_no_take_on_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |-> !req_ready)
      else $error("input taken during register write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red_out) &&
         $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end)))
      else $error("stalled result changed");

endmodule

bind separable_box_blur_rgb_top sbb_checker u_sbb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_end (rsp_frame_end),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_pready    (csr_pready)
);
`default_nettype wire
